// ----- design/tct_pkg.sv -----
`default_nettype none

package tct_pkg;

	// Widths of the grid registers and the cell fields.
	localparam int DIV_W = 9;
	localparam int CELL_W = 8;
	localparam int REM_W = 9;
	localparam int RAD_W = 16;
	localparam int POS_W = 18;
	localparam int IDX_W = 16;
	localparam int SIN_W = 18;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_RING = 2'd0;
	localparam logic [1:0] REG_TUBE = 2'd1;
	localparam logic [1:0] REG_MAJOR = 2'd2;
	localparam logic [1:0] REG_MINOR = 2'd3;

	// Cell coordinates and grid size that travel with an item down the pipeline.
	typedef struct packed {
		logic [CELL_W-1:0] u;
		logic [CELL_W-1:0] v;
		logic [DIV_W-1:0] n;
		logic [DIV_W-1:0] m;
		logic oor;
	} side_t;

endpackage

`default_nettype wire

// ----- design/tct_div_cell.sv -----
`default_nettype none

// One step of a restoring divider for both angle lanes: each cell adds one
// quotient bit of idx * 2^QW / div and hands the remainder to its neighbor.
module tct_div_cell #(
	parameter int QW = 16
) (
	input wire clk,
	input wire en,
	input tct_pkg::side_t side_d,
	input wire [tct_pkg::REM_W-1:0] rem_u_d,
	input wire [tct_pkg::REM_W-1:0] rem_v_d,
	input wire [QW-1:0] q_u_d,
	input wire [QW-1:0] q_v_d,
	output tct_pkg::side_t side_q,
	output logic [tct_pkg::REM_W-1:0] rem_u_q,
	output logic [tct_pkg::REM_W-1:0] rem_v_q,
	output logic [QW-1:0] q_u_q,
	output logic [QW-1:0] q_v_q
);
	import tct_pkg::*;

	logic [REM_W:0] dbl_u, dbl_v;
	logic ge_u, ge_v;
	logic [REM_W:0] sub_u, sub_v;

	// Shift the remainder left and try to take the divisor out.
	always_comb begin
		dbl_u = {rem_u_d, 1'b0};
		dbl_v = {rem_v_d, 1'b0};
		ge_u = dbl_u >= (REM_W+1)'(side_d.n);
		ge_v = dbl_v >= (REM_W+1)'(side_d.m);
		sub_u = ge_u ? dbl_u - (REM_W+1)'(side_d.n) : dbl_u;
		sub_v = ge_v ? dbl_v - (REM_W+1)'(side_d.m) : dbl_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_d;
			rem_u_q <= sub_u[REM_W-1:0];
			rem_v_q <= sub_v[REM_W-1:0];
			q_u_q <= {q_u_d[QW-2:0], ge_u};
			q_v_q <= {q_v_d[QW-2:0], ge_v};
		end
	end

endmodule

`default_nettype wire

// ----- design/tct_sine.sv -----
`default_nettype none

// Sine of a turn fraction in six stages: quadrant fold, then the odd Taylor
// polynomial by Horner's rule, one multiply per stage, then rounding to Q16.
module tct_sine #(
	parameter int ANGLE_BITS = 16
) (
	input wire clk,
	input wire [5:0] en,
	input wire [ANGLE_BITS-1:0] angle,
	output logic signed [tct_pkg::SIN_W-1:0] sine_q
);
	import tct_pkg::*;

	localparam int SH = 32 - ANGLE_BITS;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [30:0] C1 = 31'd1686629713;
	localparam logic [30:0] C3 = 31'd693598668;
	localparam logic [30:0] C5 = 31'd85569306;
	localparam logic [30:0] C7 = 31'd5026995;
	localparam logic [30:0] C9 = 31'd172272;

	logic [30:0] t_fold;
	logic [29:0] t_raw;
	logic [61:0] pr1, pr2, pr3, pr4, pr5, pr6;
	logic [31:0] s_raw;
	logic [30:0] s_clamp, s_sum;
	logic [16:0] s_rnd, s_mag;

	logic [30:0] t_s1, t_s2, t_s3, t_s4, t_s5;
	logic [30:0] t2_s1, t2_s2, t2_s3, t2_s4;
	logic [30:0] p_s2, p_s3, p_s4, p_s5;
	logic neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;

	// Fold the angle into the first quadrant.
	always_comb begin
		t_raw = 30'(angle[ANGLE_BITS-3:0]) << SH;
		t_fold = angle[ANGLE_BITS-2] ? ONE_Q30 - {1'b0, t_raw} : {1'b0, t_raw};
		pr1 = 62'(t_fold) * 62'(t_fold);
		pr2 = 62'(t2_s1) * 62'(C9);
		pr3 = 62'(t2_s2) * 62'(p_s2);
		pr4 = 62'(t2_s3) * 62'(p_s3);
		pr5 = 62'(t2_s4) * 62'(p_s4);
		pr6 = 62'(t_s5) * 62'(p_s5);
	end

	// Horner chain, each partial product truncated to Q30.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			t_s1 <= t_fold;
			t2_s1 <= pr1[60:30];
			neg_s1 <= angle[ANGLE_BITS-1];
		end
		if (en[1]) begin
			t_s2 <= t_s1;
			t2_s2 <= t2_s1;
			neg_s2 <= neg_s1;
			p_s2 <= C7 - pr2[60:30];
		end
		if (en[2]) begin
			t_s3 <= t_s2;
			t2_s3 <= t2_s2;
			neg_s3 <= neg_s2;
			p_s3 <= C5 - pr3[60:30];
		end
		if (en[3]) begin
			t_s4 <= t_s3;
			t2_s4 <= t2_s3;
			neg_s4 <= neg_s3;
			p_s4 <= C3 - pr4[60:30];
		end
		if (en[4]) begin
			t_s5 <= t_s4;
			neg_s5 <= neg_s4;
			p_s5 <= C1 - pr5[60:30];
		end
	end

	// Clamp to one, round to Q16, clamp again and apply the quadrant sign.
	always_comb begin
		s_raw = pr6[61:30];
		s_clamp = (s_raw > 32'(ONE_Q30)) ? ONE_Q30 : s_raw[30:0];
		s_sum = s_clamp + 31'd8192;
		s_rnd = s_sum[30:14];
		s_mag = (s_rnd > 17'd65536) ? 17'd65536 : s_rnd;
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			sine_q <= neg_s5 ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
		end
	end

endmodule

`default_nettype wire

// ----- design/torus_cell_tessellator_top.sv -----
`default_nettype none

// Torus cell tessellator. Each transfer on the cell channel carries one grid
// cell (cell_u around the main axis, cell_v around the tube); one transfer on
// the vertex channel returns its vertex in signed Q17.0 and the six corner
// indices of the two triangles joining it to its wrapped neighbors. A cell
// outside the grid returns all zeros with out_of_range set. The block takes
// one cell per cycle unless a held output backs up to the input. ANGLE_BITS
// divider cells produce the angles one bit each, six stages evaluate the sine
// polynomial, and two stages form the position. Every stage has its own valid
// bit, so bubbles close up while the output is held. Registers are written
// through wr_en/wr_index/wr_data; the user must write them only while no cell
// is in flight, which the block itself does not enforce.
module torus_cell_tessellator_top #(
	parameter int MAX_DIVISIONS = 256,
	parameter int ANGLE_BITS = 16
) (
	input wire clk,
	input wire arst_n,
	input wire wr_en,
	input wire [1:0] wr_index,
	input wire [15:0] wr_data,
	input wire cell_valid,
	output logic cell_ready,
	input wire [tct_pkg::CELL_W-1:0] cell_u,
	input wire [tct_pkg::CELL_W-1:0] cell_v,
	output logic vtx_valid,
	input wire vtx_ready,
	output logic signed [tct_pkg::POS_W-1:0] pos_x,
	output logic signed [tct_pkg::POS_W-1:0] pos_y,
	output logic signed [tct_pkg::POS_W-1:0] pos_z,
	output logic [tct_pkg::IDX_W-1:0] tri_a,
	output logic [tct_pkg::IDX_W-1:0] tri_b,
	output logic [tct_pkg::IDX_W-1:0] tri_c,
	output logic [tct_pkg::IDX_W-1:0] tri_d,
	output logic [tct_pkg::IDX_W-1:0] tri_e,
	output logic [tct_pkg::IDX_W-1:0] tri_f,
	output logic out_of_range
);
	import tct_pkg::*;

	localparam int AB = ANGLE_BITS;
	localparam int SB = AB;
	localparam int NST = AB + 8;
	localparam logic [DIV_W-1:0] MAXD = DIV_W'(MAX_DIVISIONS);
	localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [39:0] val);
		logic signed [39:0] hi, lo;
		hi = 40'sd131071;
		lo = -40'sd131072;
		if (val > hi) return POS_W'(hi);
		if (val < lo) return POS_W'(lo);
		return val[POS_W-1:0];
	endfunction

	// Configuration registers.
	logic [DIV_W-1:0] ring_q, tube_q;
	logic [RAD_W-1:0] major_q, minor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= 9'd32;
			tube_q <= 9'd16;
			major_q <= 16'd512;
			minor_q <= 16'd128;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RING: ring_q <= wr_data[DIV_W-1:0];
				REG_TUBE: tube_q <= wr_data[DIV_W-1:0];
				REG_MAJOR: major_q <= wr_data;
				REG_MINOR: minor_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Stage valid bits; a stage loads when it is empty or its successor loads.
	logic [NST-1:0] vld_q, rdy;

	always_comb begin
		rdy[NST-1] = !vld_q[NST-1] || vtx_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) vld_q[0] <= cell_valid;
			for (int k = 1; k < NST; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign cell_ready = rdy[0];
	assign vtx_valid = vld_q[NST-1];

	// Grid check at the input.
	logic [DIV_W-1:0] n_eff, m_eff;
	side_t sd [AB+1];
	logic [REM_W-1:0] rem_u [AB+1];
	logic [REM_W-1:0] rem_v [AB+1];
	logic [AB-1:0] q_u [AB+1];
	logic [AB-1:0] q_v [AB+1];

	always_comb begin
		n_eff = (ring_q > MAXD) ? MAXD : ring_q;
		m_eff = (tube_q > MAXD) ? MAXD : tube_q;
		sd[0].u = cell_u;
		sd[0].v = cell_v;
		sd[0].n = n_eff;
		sd[0].m = m_eff;
		sd[0].oor = (DIV_W'(cell_u) >= n_eff) || (DIV_W'(cell_v) >= m_eff);
		rem_u[0] = REM_W'(cell_u);
		rem_v[0] = REM_W'(cell_v);
		q_u[0] = '0;
		q_v[0] = '0;
	end

	// Row of divider cells producing the turn fractions.
	for (genvar g = 0; g < AB; g++) begin : g_div
		tct_div_cell #(.QW(AB)) u_cell (
			.clk(clk),
			.en(rdy[g]),
			.side_d(sd[g]),
			.rem_u_d(rem_u[g]),
			.rem_v_d(rem_v[g]),
			.q_u_d(q_u[g]),
			.q_v_d(q_v[g]),
			.side_q(sd[g+1]),
			.rem_u_q(rem_u[g+1]),
			.rem_v_q(rem_v[g+1]),
			.q_u_q(q_u[g+1]),
			.q_v_q(q_v[g+1])
		);
	end

	// Four sine units: cosine is the sine a quarter turn later.
	logic signed [SIN_W-1:0] sphi, cphi, sth, cth;

	tct_sine #(.ANGLE_BITS(AB)) u_sphi (
		.clk(clk), .en(rdy[SB+5:SB]), .angle(q_u[AB]), .sine_q(sphi));
	tct_sine #(.ANGLE_BITS(AB)) u_cphi (
		.clk(clk), .en(rdy[SB+5:SB]), .angle(q_u[AB] + QUARTER), .sine_q(cphi));
	tct_sine #(.ANGLE_BITS(AB)) u_sth (
		.clk(clk), .en(rdy[SB+5:SB]), .angle(q_v[AB]), .sine_q(sth));
	tct_sine #(.ANGLE_BITS(AB)) u_cth (
		.clk(clk), .en(rdy[SB+5:SB]), .angle(q_v[AB] + QUARTER), .sine_q(cth));

	// Cell data follows the sine stages.
	side_t sds_q [6];

	always_ff @(posedge clk) begin
		if (rdy[SB]) sds_q[0] <= sd[AB];
		for (int k = 1; k < 6; k++) begin
			if (rdy[SB+k]) sds_q[k] <= sds_q[k-1];
		end
	end

	// Tube radius terms and the triangle indices.
	side_t s6;
	logic signed [34:0] r_cth, r_sth, w_val;
	logic signed [39:0] y_sh;
	logic [DIV_W-1:0] un9, vn9;
	logic [CELL_W-1:0] un, vn;
	logic [16:0] base_v, base_vn;

	always_comb begin
		s6 = sds_q[5];
		r_cth = 35'($signed({1'b0, minor_q})) * 35'(cth);
		r_sth = 35'($signed({1'b0, minor_q})) * 35'(sth);
		w_val = $signed({3'b000, major_q, 16'h0000}) + r_cth;
		y_sh = 40'((r_sth + 35'sd32768) >>> 16);
		un9 = DIV_W'(s6.u) + DIV_W'(1);
		vn9 = DIV_W'(s6.v) + DIV_W'(1);
		un = (un9 == s6.n) ? '0 : un9[CELL_W-1:0];
		vn = (vn9 == s6.m) ? '0 : vn9[CELL_W-1:0];
		base_v = 17'(s6.v) * 17'(s6.n);
		base_vn = 17'(vn) * 17'(s6.n);
	end

	logic signed [34:0] w_s7;
	logic signed [SIN_W-1:0] cphi_s7, sphi_s7;
	logic signed [POS_W-1:0] y_s7;
	logic [IDX_W-1:0] ta_s7, tb_s7, tc_s7, te_s7;
	logic oor_s7;

	always_ff @(posedge clk) begin
		if (rdy[SB+6]) begin
			w_s7 <= w_val;
			cphi_s7 <= cphi;
			sphi_s7 <= sphi;
			y_s7 <= sat_pos(y_sh);
			ta_s7 <= IDX_W'(base_vn + 17'(s6.u));
			tb_s7 <= IDX_W'(base_v + 17'(s6.u));
			tc_s7 <= IDX_W'(base_vn + 17'(un));
			te_s7 <= IDX_W'(base_v + 17'(un));
			oor_s7 <= s6.oor;
		end
	end

	// Main-axis rotation and the output register.
	logic signed [53:0] px, pz;
	logic signed [39:0] x_sh, z_sh;

	always_comb begin
		px = 54'(w_s7) * 54'(cphi_s7) + 54'sh8000_0000;
		pz = 54'(w_s7) * 54'(sphi_s7) + 54'sh8000_0000;
		x_sh = 40'(px >>> 32);
		z_sh = 40'(pz >>> 32);
	end

	always_ff @(posedge clk) begin
		if (rdy[NST-1]) begin
			pos_x <= oor_s7 ? '0 : sat_pos(x_sh);
			pos_y <= oor_s7 ? '0 : y_s7;
			pos_z <= oor_s7 ? '0 : sat_pos(z_sh);
			tri_a <= oor_s7 ? '0 : ta_s7;
			tri_b <= oor_s7 ? '0 : tb_s7;
			tri_c <= oor_s7 ? '0 : tc_s7;
			tri_d <= oor_s7 ? '0 : tb_s7;
			tri_e <= oor_s7 ? '0 : te_s7;
			tri_f <= oor_s7 ? '0 : tc_s7;
			out_of_range <= oor_s7;
		end
	end

	// A cell outside the grid returns nothing but the flag.
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && out_of_range |-> pos_x == '0 && pos_y == '0 && tri_a == '0)
		else $error("out-of-range result carries data");

	// Both triangles share the vertex itself and its diagonal neighbor as corners.
	a_shared_corner: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid |-> tri_b == tri_d && tri_c == tri_f)
		else $error("shared triangle corners differ");

	// An accepted cell occupies the first stage.
	a_first_stage: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && cell_ready |=> vld_q[0])
		else $error("accepted cell lost at the first stage");

	// A held result is not overwritten.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && !vtx_ready |=> vtx_valid && $stable(tri_b) && $stable(pos_x))
		else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- verif/tct_vertex_checker.sv -----
`default_nettype none

module tct_vertex_checker (
	input wire clk,
	input wire arst_n,
	input wire wr_en,
	input wire [1:0] wr_index,
	input wire [15:0] wr_data,
	input wire cell_valid,
	input wire cell_ready,
	input wire [tct_pkg::CELL_W-1:0] cell_u,
	input wire [tct_pkg::CELL_W-1:0] cell_v,
	input wire vtx_valid,
	input wire vtx_ready,
	input wire signed [tct_pkg::POS_W-1:0] pos_x,
	input wire signed [tct_pkg::POS_W-1:0] pos_y,
	input wire signed [tct_pkg::POS_W-1:0] pos_z,
	input wire [tct_pkg::IDX_W-1:0] tri_a,
	input wire [tct_pkg::IDX_W-1:0] tri_b,
	input wire [tct_pkg::IDX_W-1:0] tri_c,
	input wire [tct_pkg::IDX_W-1:0] tri_d,
	input wire [tct_pkg::IDX_W-1:0] tri_e,
	input wire [tct_pkg::IDX_W-1:0] tri_f,
	input wire out_of_range,
	output int fail_count,
	output int pending_count
);
	import tct_pkg::*;

	localparam int MAX_DIV = 256;
	localparam int ANG_BITS = 16;
	localparam longint unsigned QUARTER_ONE = 64'd1 << 30;

	typedef struct {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic [IDX_W-1:0] c;
		logic [IDX_W-1:0] d;
		logic [IDX_W-1:0] e;
		logic [IDX_W-1:0] f;
		logic oor;
	} vertex_t;

	// Shadow copy of the grid registers.
	logic [DIV_W-1:0] ring_div;
	logic [DIV_W-1:0] tube_div;
	logic [RAD_W-1:0] major_r;
	logic [RAD_W-1:0] minor_r;

	vertex_t expected_vertices[$];

	// Sine over the first quarter turn, Q30 angle in, Q16 out.
	function automatic longint quarter_wave(longint unsigned t);
		longint unsigned t2;
		longint unsigned p;
		longint unsigned s;
		t2 = (t * t) >> 30;
		p = 64'd5026995 - ((t2 * 64'd172272) >> 30);
		p = 64'd85569306 - ((t2 * p) >> 30);
		p = 64'd693598668 - ((t2 * p) >> 30);
		p = 64'd1686629713 - ((t2 * p) >> 30);
		s = (t * p) >> 30;
		if (s > QUARTER_ONE)
			s = QUARTER_ONE;
		s = (s + 64'd8192) >> 14;
		if (s > 64'd65536)
			s = 64'd65536;
		return longint'(s);
	endfunction

	// Sine of a 32-bit turn fraction; the top two bits pick the quadrant.
	function automatic longint turn_sin(logic [31:0] ang);
		longint unsigned t;
		longint s;
		t = longint'(ang[29:0]);
		if (ang[30])
			t = QUARTER_ONE - t;
		s = quarter_wave(t);
		return ang[31] ? -s : s;
	endfunction

	function automatic logic [31:0] cell_angle(int idx, int div);
		longint unsigned q;
		q = (longint'(idx) << ANG_BITS) / div;
		return {q[ANG_BITS-1:0], {(32-ANG_BITS){1'b0}}};
	endfunction

	// Round half up after the shift, then saturate to the position range.
	function automatic logic signed [POS_W-1:0] scale_pos(longint val, int sh);
		longint r;
		r = (val + (longint'(1) << (sh - 1))) >>> sh;
		if (r > 131071)
			r = 131071;
		if (r < -131072)
			r = -131072;
		return r[POS_W-1:0];
	endfunction

	function automatic vertex_t predict_vertex(int u, int v);
		vertex_t vx;
		int n;
		int m;
		int un;
		int vn;
		logic [31:0] aphi;
		logic [31:0] ath;
		longint w;
		n = (ring_div > MAX_DIV) ? MAX_DIV : int'(ring_div);
		m = (tube_div > MAX_DIV) ? MAX_DIV : int'(tube_div);
		vx = '{default: '0};
		if (u >= n || v >= m) begin
			vx.oor = 1'b1;
			return vx;
		end
		aphi = cell_angle(u, n);
		ath = cell_angle(v, m);
		w = (longint'(major_r) << 16) + longint'(minor_r) * turn_sin(ath + 32'h4000_0000);
		vx.x = scale_pos(w * turn_sin(aphi + 32'h4000_0000), 32);
		vx.y = scale_pos(longint'(minor_r) * turn_sin(ath), 16);
		vx.z = scale_pos(w * turn_sin(aphi), 32);
		un = (u + 1) % n;
		vn = (v + 1) % m;
		vx.a = IDX_W'(vn * n + u);
		vx.b = IDX_W'(v * n + u);
		vx.c = IDX_W'(vn * n + un);
		vx.d = IDX_W'(v * n + u);
		vx.e = IDX_W'(v * n + un);
		vx.f = IDX_W'(vn * n + un);
		return vx;
	endfunction

	function automatic int compare_field(string name, longint exp_val, longint act_val);
		if (exp_val != act_val) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
			return 1;
		end
		return 0;
	endfunction

	// Track register writes, predict on every cell transfer, check every vertex transfer.
	always @(posedge clk or negedge arst_n) begin
		vertex_t exp_v;
		int errs;
		if (!arst_n) begin
			ring_div = 9'd32;
			tube_div = 9'd16;
			major_r = 16'd512;
			minor_r = 16'd128;
			expected_vertices.delete();
			fail_count = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_RING: ring_div = wr_data[DIV_W-1:0];
					REG_TUBE: tube_div = wr_data[DIV_W-1:0];
					REG_MAJOR: major_r = wr_data;
					REG_MINOR: minor_r = wr_data;
					default: ;
				endcase
			end
			if (cell_valid && cell_ready)
				expected_vertices = {expected_vertices,
					predict_vertex(int'(cell_u), int'(cell_v))};
			if (vtx_valid && vtx_ready) begin
				if (expected_vertices.size() == 0) begin
					$error("vertex transfer with no cell outstanding");
					fail_count++;
				end else begin
					exp_v = expected_vertices.pop_front();
					errs = 0;
					errs += compare_field("pos_x", exp_v.x, pos_x);
					errs += compare_field("pos_y", exp_v.y, pos_y);
					errs += compare_field("pos_z", exp_v.z, pos_z);
					errs += compare_field("tri_a", exp_v.a, tri_a);
					errs += compare_field("tri_b", exp_v.b, tri_b);
					errs += compare_field("tri_c", exp_v.c, tri_c);
					errs += compare_field("tri_d", exp_v.d, tri_d);
					errs += compare_field("tri_e", exp_v.e, tri_e);
					errs += compare_field("tri_f", exp_v.f, tri_f);
					errs += compare_field("out_of_range", exp_v.oor, out_of_range);
					if (errs != 0)
						fail_count++;
				end
			end
		end
		pending_count = expected_vertices.size();
	end

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`default_nettype none

module tb_top;
	import tct_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [1:0] wr_index = REG_RING;
	logic [15:0] wr_data = '0;
	logic cell_valid = 1'b0;
	logic cell_ready;
	logic [CELL_W-1:0] cell_u = '0;
	logic [CELL_W-1:0] cell_v = '0;
	logic vtx_valid;
	logic vtx_ready = 1'b0;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic [IDX_W-1:0] tri_a, tri_b, tri_c, tri_d, tri_e, tri_f;
	logic out_of_range;
	int fail_count;
	int pending_count;
	int cycle_count = 0;

	// Idling is switched off for some phases; hold_off asks the receiver for a long stall.
	bit gaps_on = 1'b1;
	bit hold_off = 1'b0;
	int ring_n = 32;
	int tube_m = 16;

	always #10 clk = ~clk;

	torus_cell_tessellator_top uut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.cell_valid(cell_valid), .cell_ready(cell_ready), .cell_u(cell_u), .cell_v(cell_v),
		.vtx_valid(vtx_valid), .vtx_ready(vtx_ready), .pos_x(pos_x), .pos_y(pos_y),
		.pos_z(pos_z), .tri_a(tri_a), .tri_b(tri_b), .tri_c(tri_c), .tri_d(tri_d),
		.tri_e(tri_e), .tri_f(tri_f), .out_of_range(out_of_range)
	);

	tct_vertex_checker u_check (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.cell_valid(cell_valid), .cell_ready(cell_ready), .cell_u(cell_u), .cell_v(cell_v),
		.vtx_valid(vtx_valid), .vtx_ready(vtx_ready), .pos_x(pos_x), .pos_y(pos_y),
		.pos_z(pos_z), .tri_a(tri_a), .tri_b(tri_b), .tri_c(tri_c), .tri_d(tri_d),
		.tri_e(tri_e), .tri_f(tri_f), .out_of_range(out_of_range),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	// Offer one cell after an optional gap, during which valid is low.
	task automatic send_cell(input int u, input int v);
		int gap;
		gap = gaps_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			cell_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cell_u <= CELL_W'(u);
		cell_v <= CELL_W'(v);
		cell_valid <= 1'b1;
		do @(posedge clk); while (!cell_ready);
	endtask

	// Drain the pipeline, then write all four grid registers.
	task automatic set_grid(input int n, input int m, input int major, input int minor);
		if (cell_valid) begin
			cell_valid <= 1'b0;
			@(posedge clk);
		end
		while (pending_count != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= REG_RING;
		wr_data <= 16'(n);
		@(posedge clk);
		wr_index <= REG_TUBE;
		wr_data <= 16'(m);
		@(posedge clk);
		wr_index <= REG_MAJOR;
		wr_data <= 16'(major);
		@(posedge clk);
		wr_index <= REG_MINOR;
		wr_data <= 16'(minor);
		@(posedge clk);
		wr_en <= 1'b0;
		ring_n = (n > 256) ? 256 : n;
		tube_m = (m > 256) ? 256 : m;
	endtask

	function automatic int pick_div();
		case ($urandom_range(0, 7))
			0: return 3;
			1: return 256;
			2: return $urandom_range(257, 511);
			3: return $urandom_range(0, 2);
			default: return $urandom_range(3, 256);
		endcase
	endfunction

	// Receiver: a random stall before each vertex, or a long one on request.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				gap = 400;
				hold_off = 1'b0;
			end else begin
				gap = gaps_on ? $urandom_range(0, 16) : 0;
			end
			if (gap > 0) begin
				vtx_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			vtx_ready <= 1'b1;
			do @(posedge clk); while (!vtx_valid);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int u;
		int v;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset grid: corners, edges just outside, and the widest field values.
		send_cell(0, 0);
		send_cell(31, 15);
		send_cell(8, 4);
		send_cell(16, 8);
		send_cell(24, 12);
		send_cell(32, 0);
		send_cell(0, 16);
		send_cell(255, 255);

		// Oversized divisions clamp to the maximum; largest radii saturate.
		set_grid(511, 300, 65535, 65535);
		send_cell(255, 255);
		send_cell(0, 0);
		send_cell(128, 128);
		send_cell(64, 192);
		send_cell(170, 85);

		// Zero divisions put every cell outside the grid.
		set_grid(0, 5, 0, 0);
		send_cell(0, 0);
		send_cell(1, 2);

		// Tiny divisions, first with zero radii and then with nonzero radii.
		set_grid(1, 2, 0, 0);
		send_cell(0, 0);
		send_cell(0, 1);
		send_cell(1, 0);
		set_grid(3, 3, 255, 65535);
		send_cell(2, 2);
		send_cell(1, 0);
		send_cell(3, 1);

		// Random phases: mostly cells inside the grid, the rest anywhere.
		for (int phase = 0; phase < 9; phase++) begin
			if (phase == 0)
				set_grid(256, 256, $urandom_range(0, 65535), $urandom_range(0, 65535));
			else
				set_grid(pick_div(), pick_div(), $urandom_range(0, 65535),
					$urandom_range(0, 65535));
			gaps_on = (phase % 3) != 1;
			if (phase == 2)
				hold_off = 1'b1;
			for (int k = 0; k < 150; k++) begin
				if (ring_n > 0 && tube_m > 0 && $urandom_range(0, 99) < 85) begin
					u = $urandom_range(0, ring_n - 1);
					v = $urandom_range(0, tube_m - 1);
				end else begin
					u = $urandom_range(0, 255);
					v = $urandom_range(0, 255);
				end
				send_cell(u, v);
			end
		end
		cell_valid <= 1'b0;

		while (pending_count != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
